// ----- hw/rtl/key_debounce_long_press_repeat_assert.svh -----
// Assertion macros for the key debounce / long press / repeat block.
// Clock clk_i and reset rst_ni must be visible where these are used.
`ifndef KEY_DEBOUNCE_LONG_PRESS_REPEAT_ASSERT_SVH
`define KEY_DEBOUNCE_LONG_PRESS_REPEAT_ASSERT_SVH

// Same-cycle implication
`define KDLPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define KDLPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/kdlpr_pkg.sv -----
// Shared constants, event codes, register indexes and types for the key qualifier.
// No dependencies.
package kdlpr_pkg;

  localparam int unsigned NUM_KEYS_DEF = 4;
  localparam int unsigned PIN_KEYS     = 4;   // keys carried by the pin field
  localparam int unsigned TIMER_W      = 32;
  localparam int unsigned SCAN_W       = 8;
  localparam int unsigned MS_W         = 16;
  localparam int unsigned EV_W         = 2;
  localparam int unsigned EVENTS_W     = 8;
  localparam int unsigned MASK_W       = 4;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [EV_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EV_W-1:0] EV_SHORT  = 2'd1;
  localparam logic [EV_W-1:0] EV_LONG   = 2'd2;
  localparam logic [EV_W-1:0] EV_REPEAT = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELIVERY    = 3'd4;

  localparam logic [SCAN_W-1:0] SCAN_PERIOD_RST = 8'd10;
  localparam logic [MS_W-1:0]   DEBOUNCE_RST    = 16'd20;
  localparam logic [MS_W-1:0]   LONG_PRESS_RST  = 16'd1000;
  localparam logic [MS_W-1:0]   REPEAT_RST      = 16'd200;
  localparam logic [MASK_W-1:0] DELIVERY_RST    = 4'd0;

  // Timing settings shared by all lanes
  typedef struct packed {
    logic [SCAN_W-1:0] scan_period;
    logic [MS_W-1:0]   debounce;
    logic [MS_W-1:0]   long_thresh;
    logic [MS_W-1:0]   repeat_ival;
  } lane_cfg_t;

  // Per-transfer strobes to every lane
  typedef struct packed {
    logic tick;
    logic clear;
  } lane_ctl_t;

endpackage

// ----- hw/rtl/kdlpr_if.sv -----
// Valid/ready channel interfaces: item input, result output, register write.
// Depends on kdlpr_pkg.
interface kdlpr_in_if import kdlpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                operation;
  logic [PIN_KEYS-1:0] pin_levels;

  modport source (output valid, output operation, output pin_levels, input ready);
  modport sink   (input valid, input operation, input pin_levels, output ready);
endinterface

interface kdlpr_out_if import kdlpr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [EVENTS_W-1:0] events;

  modport source (output valid, output events, input ready);
  modport sink   (input valid, input events, output ready);
endinterface

interface kdlpr_cfg_if import kdlpr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/kdlpr_lane.sv -----
// One key's released/debounce/pressed machine with hold timer and event latch.
// Depends on kdlpr_pkg.
module kdlpr_lane import kdlpr_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lane_ctl_t       ctl_i,
  input  lane_cfg_t       cfg_i,
  input  logic            pressed_i,
  output logic [EV_W-1:0] pend_o
);

  localparam logic [1:0] PH_RELEASED = 2'd0;
  localparam logic [1:0] PH_DEBOUNCE = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;

  logic [1:0]         phase_q, phase_d;
  logic [TIMER_W-1:0] hold_q, hold_d;
  logic [TIMER_W-1:0] nrt_q, nrt_d;
  logic               long_q, long_d;
  logic [EV_W-1:0]    pend_q, pend_d;

  logic [TIMER_W-1:0] hold_inc;
  logic [TIMER_W-1:0] rep_ext;
  logic               none_pending;

  assign hold_inc     = hold_q + {{(TIMER_W-SCAN_W){1'b0}}, cfg_i.scan_period};
  assign rep_ext      = {{(TIMER_W-MS_W){1'b0}}, cfg_i.repeat_ival};
  assign none_pending = (pend_q == EV_NONE);

  always_comb begin
    phase_d = phase_q;
    hold_d  = hold_q;
    nrt_d   = nrt_q;
    long_d  = long_q;
    pend_d  = pend_q;
    if (ctl_i.clear) begin
      pend_d = EV_NONE;
    end else if (ctl_i.tick) begin
      case (phase_q)
        PH_DEBOUNCE: begin
          hold_d = hold_inc;
          if (pressed_i && hold_inc >= {{(TIMER_W-MS_W){1'b0}}, cfg_i.debounce}) begin
            phase_d = PH_PRESSED;
          end else if (!pressed_i) begin
            phase_d = PH_RELEASED;  // timer kept
          end
        end
        PH_PRESSED: begin
          hold_d = hold_inc;
          if (!pressed_i) begin
            if (!long_q && none_pending) begin
              pend_d = EV_SHORT;
            end
            phase_d = PH_RELEASED;
            hold_d  = '0;
            long_d  = 1'b0;
          end else if (!long_q &&
                       hold_inc >= {{(TIMER_W-MS_W){1'b0}}, cfg_i.long_thresh}) begin
            if (none_pending) begin
              pend_d = EV_LONG;
              long_d = 1'b1;
              nrt_d  = hold_inc + rep_ext;
            end
          end else if (long_q && hold_inc >= nrt_q) begin
            if (none_pending) begin
              pend_d = EV_REPEAT;
              nrt_d  = nrt_q + rep_ext;
            end
          end
        end
        default: begin
          // released, and the unused code behaves the same
          phase_d = PH_RELEASED;
          if (pressed_i) begin
            phase_d = PH_DEBOUNCE;
            hold_d  = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RELEASED;
      hold_q  <= '0;
      nrt_q   <= '0;
      long_q  <= 1'b0;
      pend_q  <= EV_NONE;
    end else begin
      phase_q <= phase_d;
      hold_q  <= hold_d;
      nrt_q   <= nrt_d;
      long_q  <= long_d;
      pend_q  <= pend_d;
    end
  end

  assign pend_o = pend_q;

endmodule

// ----- hw/rtl/kdlpr_merge.sv -----
// Merge stage: packs delivered pending events into the result and holds it
// in the output register. Depends on kdlpr_pkg and kdlpr_out_if.
module kdlpr_merge import kdlpr_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic                           collect_i,
  input  logic [NUM_KEYS-1:0][EV_W-1:0]  pend_i,
  input  logic [MASK_W-1:0]              mask_i,
  output logic                           ready_o,
  kdlpr_out_if.source                    out_o
);

  // only keys inside the pin field can be delivered
  localparam int unsigned DelivKeys = (NUM_KEYS < PIN_KEYS) ? NUM_KEYS : PIN_KEYS;

  logic                valid_q;
  logic [EVENTS_W-1:0] events_q;
  logic [EVENTS_W-1:0] events_d;

  always_comb begin
    events_d = '0;
    if (collect_i) begin
      for (int k = 0; k < int'(DelivKeys); k++) begin
        if (mask_i[k]) begin
          events_d[2*k +: EV_W] = pend_i[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      events_q <= events_d;
    end
  end

  assign ready_o      = !valid_q || out_o.ready;
  assign out_o.valid  = valid_q;
  assign out_o.events = events_q;

endmodule

// ----- hw/rtl/key_debounce_long_press_repeat.sv -----
// Key debounce, long-press and auto-repeat qualifier: top level.
// Depends on kdlpr_pkg, the kdlpr interfaces, kdlpr_lane, kdlpr_merge, assert macros.
//
// Usage:
//   in_i   carries one item per transfer: operation 0 is a scan tick with the
//          active-low pin levels of up to four keys, operation 1 collects the
//          pending events of delivered keys and clears all pending events.
//   out_o  returns exactly one result per item: 2 bits per key
//          (none/short/long/repeat); a scan tick returns zero.
//   cfg_i  writes the timing registers and the delivery mask; index is the
//          register number, unknown indexes are ignored. Always ready; write
//          only while no item is in flight.
// Timing: one lane per key updates in the cycle of the transfer, so a new item
//   is taken every cycle; the result is registered and appears in the cycle
//   after the transfer. The per-lane 32-bit timer add plus compare sets the cycle.
// Stall: the result waits in the output register; a new item is taken in
//   the same cycle that the waiting result leaves, otherwise in_i.ready drops.
// Reset: all keys released, timers and pending events cleared, registers at
//   their defaults, no result held.
`include "key_debounce_long_press_repeat_assert.svh"

module key_debounce_long_press_repeat import kdlpr_pkg::*; #(
  parameter int unsigned NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kdlpr_in_if.sink    in_i,
  kdlpr_out_if.source out_o,
  kdlpr_cfg_if.sink   cfg_i
);

  logic [SCAN_W-1:0] scan_period_q;
  logic [MS_W-1:0]   debounce_q;
  logic [MS_W-1:0]   long_press_q;
  logic [MS_W-1:0]   repeat_q;
  logic [MASK_W-1:0] delivery_q;

  logic                          in_xfer;
  logic                          merge_ready;
  lane_ctl_t                     ctl;
  lane_cfg_t                     lcfg;
  logic [NUM_KEYS-1:0][EV_W-1:0] pend_all;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_period_q <= SCAN_PERIOD_RST;
      debounce_q    <= DEBOUNCE_RST;
      long_press_q  <= LONG_PRESS_RST;
      repeat_q      <= REPEAT_RST;
      delivery_q    <= DELIVERY_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SCAN_PERIOD: scan_period_q <= cfg_i.data[SCAN_W-1:0];
        REG_DEBOUNCE:    debounce_q    <= cfg_i.data[MS_W-1:0];
        REG_LONG_PRESS:  long_press_q  <= cfg_i.data[MS_W-1:0];
        REG_REPEAT:      repeat_q      <= cfg_i.data[MS_W-1:0];
        REG_DELIVERY:    delivery_q    <= cfg_i.data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = merge_ready;
  assign in_xfer     = in_i.valid && merge_ready;

  assign ctl.tick  = in_xfer && !in_i.operation;
  assign ctl.clear = in_xfer && in_i.operation;

  assign lcfg.scan_period = scan_period_q;
  assign lcfg.debounce    = debounce_q;
  assign lcfg.long_thresh = long_press_q;
  assign lcfg.repeat_ival = repeat_q;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pressed;
    if (k < PIN_KEYS) begin : g_pin
      assign pressed = !in_i.pin_levels[k];
    end else begin : g_nopin
      assign pressed = 1'b0;
    end

    kdlpr_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .cfg_i     (lcfg),
      .pressed_i (pressed),
      .pend_o    (pend_all[k])
    );
  end

  kdlpr_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (in_xfer),
    .collect_i (in_i.operation),
    .pend_i    (pend_all),
    .mask_i    (delivery_q),
    .ready_o   (merge_ready),
    .out_o     (out_o)
  );

  // A collect leaves no pending event behind
  `KDLPR_ASSERT_NEXT(a_collect_clears, ctl.clear, pend_all == '0, "pending not cleared")
  // A scan tick yields a valid all-zero result
  `KDLPR_ASSERT_NEXT(a_tick_result, ctl.tick, out_o.valid && out_o.events == '0, "bad tick result")
  // Pending events only move on an item transfer
  `KDLPR_ASSERT_NEXT(a_pend_stable, !in_xfer, $stable(pend_all), "pending changed while idle")
  // Never take an item while a held result is stalled
  `KDLPR_ASSERT_NOW(a_no_overrun, out_o.valid && !out_o.ready, !in_i.ready, "result overrun")

endmodule
